@@ src/uda_pkg.sv @@
// Shared types and constants for the 32-bit binary to decimal ASCII converter.
// No dependencies; every other file in src refers to it by scoped names.
`default_nettype none

package uda_pkg;

  localparam int unsigned NumChars   = 10;
  localparam int unsigned HalfDigits = 5;

  // Division by 100000 is done as (value >> 5) / 3125 with a reciprocal multiply.
  localparam int unsigned PreShift   = 5;
  localparam int unsigned RecipShift = 39;
  localparam logic [27:0] Recip3125  = 28'hA7C5AC5;
  localparam logic [16:0] HalfDiv    = 17'd100000;

  // floor(2^28 / 10000) + 1, the scale that turns a half into a 4.28 fraction.
  localparam logic [14:0] Recip10000 = 15'd26844;

  localparam logic [7:0] FillChar  = 8'h0A;
  localparam logic [7:0] ZeroChar  = 8'h30;
  localparam logic [3:0] FullCount = 4'd10;

  typedef logic [16:0] half_t;
  typedef logic [31:0] frac_t;
  typedef logic [3:0]  digit_t;
  typedef logic [7:0]  char_t;
  typedef logic [3:0]  count_t;

  // Element i is position i, position 0 being the most significant digit.
  typedef digit_t [NumChars-1:0] digit_vec_t;
  typedef char_t  [NumChars-1:0] char_vec_t;

endpackage

`default_nettype wire

@@ src/uint32_to_decimal_ascii_core.sv @@
// Top level of the 32-bit unsigned binary to ten-digit decimal ASCII converter.
// Instantiates uda_split, uda_frac, uda_digits and uda_pack; uses uda_pkg.
//
//   port group  direction  handshake            payload
//   in_         input      in_valid/in_ready    in_value[31:0]
//   out_        output     out_valid/out_ready  out_char_0..9[7:0], out_digit_count[3:0]
//   cfg_        input      cfg_we               cfg_wdata (strip leading zeros)
//
// One word is accepted per cycle while out_ready lets the pipe drain.
// Each word passes through six register stages: reciprocal product, half split,
// fraction scale, digit extraction, leading zero count and output pack.
// Synchronous reset clears all stage valid bits and selects padded mode.
// With out_ready low every full stage holds; in_ready falls once the pipe is full.
`default_nettype none

module uint32_to_decimal_ascii_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_char_0,
  output logic [7:0]       out_char_1,
  output logic [7:0]       out_char_2,
  output logic [7:0]       out_char_3,
  output logic [7:0]       out_char_4,
  output logic [7:0]       out_char_5,
  output logic [7:0]       out_char_6,
  output logic [7:0]       out_char_7,
  output logic [7:0]       out_char_8,
  output logic [7:0]       out_char_9,
  output logic [3:0]       out_digit_count
);

  logic                cfg_strip_r;
  logic                split_valid;
  logic                split_ready;
  uda_pkg::half_t      split_hi;
  uda_pkg::half_t      split_lo;
  logic                frac_valid;
  logic                frac_ready;
  uda_pkg::frac_t      frac_hi;
  uda_pkg::frac_t      frac_lo;
  logic                dig_valid;
  logic                dig_ready;
  uda_pkg::digit_vec_t dig_vec;
  uda_pkg::char_vec_t  chars;
  uda_pkg::count_t     count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_strip_r <= 1'b0;
    end else if (cfg_we) begin
      cfg_strip_r <= cfg_wdata;
    end
  end

  uda_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_value  (in_value),
    .out_valid (split_valid),
    .out_ready (split_ready),
    .out_hi    (split_hi),
    .out_lo    (split_lo)
  );

  uda_frac u_frac (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (split_valid),
    .in_ready    (split_ready),
    .in_hi       (split_hi),
    .in_lo       (split_lo),
    .out_valid   (frac_valid),
    .out_ready   (frac_ready),
    .out_frac_hi (frac_hi),
    .out_frac_lo (frac_lo)
  );

  uda_digits u_digits (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (frac_valid),
    .in_ready   (frac_ready),
    .in_frac_hi (frac_hi),
    .in_frac_lo (frac_lo),
    .out_valid  (dig_valid),
    .out_ready  (dig_ready),
    .out_digits (dig_vec)
  );

  uda_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .strip     (cfg_strip_r),
    .in_valid  (dig_valid),
    .in_ready  (dig_ready),
    .in_digits (dig_vec),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_chars (chars),
    .out_count (count)
  );

  assign out_char_0      = chars[0];
  assign out_char_1      = chars[1];
  assign out_char_2      = chars[2];
  assign out_char_3      = chars[3];
  assign out_char_4      = chars[4];
  assign out_char_5      = chars[5];
  assign out_char_6      = chars[6];
  assign out_char_7      = chars[7];
  assign out_char_8      = chars[8];
  assign out_char_9      = chars[9];
  assign out_digit_count = count;

  // The first position always holds a digit character, never the fill code.
  a_first_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_char_0[7:4] == uda_pkg::ZeroChar[7:4])
    else $error("first character is not a digit");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_count != 4'd0) && (out_digit_count <= uda_pkg::FullCount))
    else $error("digit count out of range");

  a_short_fills_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_digit_count != uda_pkg::FullCount) |-> out_char_9 == uda_pkg::FillChar)
    else $error("unused last position not filled");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

@@ src/uda_split.sv @@
// Two pipeline stages that split the input word into high and low five-digit halves.
// Uses uda_pkg for the reciprocal constants and the half type.
`default_nettype none

module uda_split (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [31:0]   in_value,
  output logic               out_valid,
  input  wire logic          out_ready,
  output uda_pkg::half_t     out_hi,
  output uda_pkg::half_t     out_lo
);

  logic              vld_a_r;
  logic              vld_b_r;
  logic              rdy_a;
  logic              rdy_b;
  logic [31:0]       val_a_r;
  logic [54:0]       prod_a_r;
  logic [54:0]       prod_nxt;
  logic [15:0]       quot;
  logic [32:0]       hi_scaled;
  logic [32:0]       lo_full;
  uda_pkg::half_t    hi_b_r;
  uda_pkg::half_t    lo_b_r;

  assign rdy_b    = !vld_b_r || out_ready;
  assign rdy_a    = !vld_a_r || rdy_b;
  assign in_ready = rdy_a;

  assign prod_nxt  = {28'b0, in_value[31:uda_pkg::PreShift]} * {27'b0, uda_pkg::Recip3125};
  assign quot      = prod_a_r[54:uda_pkg::RecipShift];
  assign hi_scaled = {17'b0, quot} * {16'b0, uda_pkg::HalfDiv};
  assign lo_full   = {1'b0, val_a_r} - hi_scaled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        vld_a_r <= in_valid;
      end
      if (rdy_b) begin
        vld_b_r <= vld_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      val_a_r  <= in_value;
      prod_a_r <= prod_nxt;
    end
    if (rdy_b && vld_a_r) begin
      hi_b_r <= {1'b0, quot};
      lo_b_r <= lo_full[16:0];
    end
  end

  assign out_valid = vld_b_r;
  assign out_hi    = hi_b_r;
  assign out_lo    = lo_b_r;

endmodule

`default_nettype wire

@@ src/uda_frac.sv @@
// One pipeline stage that scales both halves into 4.28 fixed-point fractions.
// Uses uda_pkg for the scale constant and the half and fraction types.
`default_nettype none

module uda_frac (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire uda_pkg::half_t in_hi,
  input  wire uda_pkg::half_t in_lo,
  output logic                out_valid,
  input  wire logic           out_ready,
  output uda_pkg::frac_t      out_frac_hi,
  output uda_pkg::frac_t      out_frac_lo
);

  logic           vld_r;
  logic           rdy;
  uda_pkg::frac_t frac_hi_r;
  uda_pkg::frac_t frac_lo_r;

  function automatic uda_pkg::frac_t to_fraction(input uda_pkg::half_t half);
    logic [31:0] prod;
    prod = {15'b0, half} * {17'b0, uda_pkg::Recip10000};
    return prod - {17'b0, half[16:2]};
  endfunction

  assign rdy      = !vld_r || out_ready;
  assign in_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      frac_hi_r <= to_fraction(in_hi);
      frac_lo_r <= to_fraction(in_lo);
    end
  end

  assign out_valid   = vld_r;
  assign out_frac_hi = frac_hi_r;
  assign out_frac_lo = frac_lo_r;

endmodule

`default_nettype wire

@@ src/uda_digits.sv @@
// One pipeline stage that pulls five digits out of each fraction by repeated times-ten.
// Uses uda_pkg for the fraction, digit and digit vector types.
`default_nettype none

module uda_digits (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire uda_pkg::frac_t in_frac_hi,
  input  wire uda_pkg::frac_t in_frac_lo,
  output logic                out_valid,
  input  wire logic           out_ready,
  output uda_pkg::digit_vec_t out_digits
);

  logic                vld_r;
  logic                rdy;
  uda_pkg::digit_vec_t digits_r;
  uda_pkg::digit_vec_t digits_nxt;

  always_comb begin
    logic [31:0] f_hi;
    logic [31:0] f_lo;
    logic [31:0] m_hi;
    logic [31:0] m_lo;
    f_hi = in_frac_hi;
    f_lo = in_frac_lo;
    digits_nxt = '0;
    for (int j = 0; j < uda_pkg::HalfDigits; j++) begin
      digits_nxt[j]                      = f_hi[31:28];
      digits_nxt[j + uda_pkg::HalfDigits] = f_lo[31:28];
      m_hi = {4'b0, f_hi[27:0]};
      m_lo = {4'b0, f_lo[27:0]};
      f_hi = (m_hi << 3) + (m_hi << 1);
      f_lo = (m_lo << 3) + (m_lo << 1);
    end
  end

  assign rdy      = !vld_r || out_ready;
  assign in_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      digits_r <= digits_nxt;
    end
  end

  assign out_valid  = vld_r;
  assign out_digits = digits_r;

endmodule

`default_nettype wire

@@ src/uda_pack.sv @@
// Two pipeline stages: leading zero count, then left-justify and ASCII encode.
// Uses uda_pkg for the character constants and vector types.
`default_nettype none

module uda_pack (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                strip,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire uda_pkg::digit_vec_t in_digits,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output uda_pkg::char_vec_t       out_chars,
  output uda_pkg::count_t          out_count
);

  logic                vld_c_r;
  logic                vld_d_r;
  logic                rdy_c;
  logic                rdy_d;
  uda_pkg::digit_vec_t digits_c_r;
  uda_pkg::count_t     lead_c_r;
  uda_pkg::count_t     lead_nxt;
  uda_pkg::digit_vec_t shifted;
  uda_pkg::count_t     count;
  uda_pkg::char_vec_t  chars_nxt;
  uda_pkg::char_vec_t  chars_d_r;
  uda_pkg::count_t     count_d_r;

  // At most nine leading zeros are dropped so one digit always remains.
  always_comb begin
    logic done;
    done     = !strip;
    lead_nxt = '0;
    for (int i = 0; i < uda_pkg::NumChars - 1; i++) begin
      if (!done && in_digits[i] == '0) begin
        lead_nxt = lead_nxt + 4'd1;
      end else begin
        done = 1'b1;
      end
    end
  end

  assign shifted = in_digits_shift(digits_c_r, lead_c_r);
  assign count   = uda_pkg::FullCount - lead_c_r;

  function automatic uda_pkg::digit_vec_t in_digits_shift(input uda_pkg::digit_vec_t d,
                                                           input uda_pkg::count_t lead);
    return d >> {lead, 2'b00};
  endfunction

  always_comb begin
    for (int i = 0; i < uda_pkg::NumChars; i++) begin
      if (4'(i) < count) begin
        chars_nxt[i] = uda_pkg::ZeroChar + {4'b0, shifted[i]};
      end else begin
        chars_nxt[i] = uda_pkg::FillChar;
      end
    end
  end

  assign rdy_d    = !vld_d_r || out_ready;
  assign rdy_c    = !vld_c_r || rdy_d;
  assign in_ready = rdy_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
    end else begin
      if (rdy_c) begin
        vld_c_r <= in_valid;
      end
      if (rdy_d) begin
        vld_d_r <= vld_c_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && in_valid) begin
      digits_c_r <= in_digits;
      lead_c_r   <= lead_nxt;
    end
    if (rdy_d && vld_c_r) begin
      chars_d_r <= chars_nxt;
      count_d_r <= count;
    end
  end

  assign out_valid = vld_d_r;
  assign out_chars = chars_d_r;
  assign out_count = count_d_r;

endmodule

`default_nettype wire

@@ tb/uda_tb_pkg.sv @@
// Expected-text tracking for the decimal ASCII converter bench: the digit
// prediction and the in-order comparison of converted words.
// Depends on uda_pkg for the character, count and vector types.
package uda_tb_pkg;
  import uda_pkg::*;

  localparam logic [31:0] HalfBase  = 32'd100000;
  localparam logic [31:0] FracScale = 32'((64'd1 << 28) / 64'd10000 + 64'd1);
  localparam char_t       AsciiZero = 8'h30;
  localparam char_t       PadChar   = 8'h0A;
  localparam int unsigned ReportMax = 10;

  typedef struct {
    logic [31:0] value;
    char_vec_t   chars;
    count_t      count;
  } decimal_text_t;

  class decimal_text_tracker;
    bit            strip;
    decimal_text_t expected_q[$];
    int unsigned   mismatches;

    function new();
      strip      = 1'b0;
      mismatches = 0;
    endfunction

    function void set_strip(bit s);
      strip = s;
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    function decimal_text_t convert(logic [31:0] value);
      decimal_text_t text;
      logic [31:0]   half [2];
      logic [31:0]   frac;
      char_t         digits [NumChars];
      int unsigned   lead;
      half[0] = value / HalfBase;
      half[1] = value % HalfBase;
      for (int h = 0; h < 2; h++) begin
        // Each half becomes a 4.28 fraction; digits come out of the top nibble.
        frac = half[h] * FracScale - half[h] / 32'd4;
        for (int k = 0; k < HalfDigits; k++) begin
          digits[h * HalfDigits + k] = AsciiZero + {4'd0, frac[31:28]};
          frac = {4'd0, frac[27:0]} * 32'd10;
        end
      end
      lead = 0;
      if (strip) begin
        while (lead < NumChars - 1 && digits[lead] == AsciiZero) lead++;
      end
      text.value = value;
      text.count = count_t'(NumChars - lead);
      for (int i = 0; i < NumChars; i++) begin
        if (i < NumChars - lead) begin
          text.chars[i] = digits[i + lead];
        end else begin
          text.chars[i] = PadChar;
        end
      end
      return text;
    endfunction

    function void note_number(logic [31:0] value);
      expected_q.push_back(convert(value));
    endfunction

    function void check_text(decimal_text_t got);
      decimal_text_t want;
      bit            bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax) begin
          $display("unexpected word: chars %h count %0d", got.chars, got.count);
        end
        return;
      end
      want = expected_q.pop_front();
      bad  = (want.count !== got.count);
      for (int i = 0; i < NumChars; i++) begin
        if (want.chars[i] !== got.chars[i]) bad = 1'b1;
      end
      if (bad) begin
        mismatches++;
        if (mismatches <= ReportMax) begin
          $display("mismatch for %0d: expected chars %h count %0d, got chars %h count %0d",
                   want.value, want.chars, want.count, got.chars, got.count);
        end
      end
    endfunction
  endclass

endpackage

@@ tb/tb.sv @@
// Top-level bench for uint32_to_decimal_ascii_core: drives numbers, the strip
// mode register and output back-pressure, and checks every converted word.
// Depends on uda_pkg and uda_tb_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uda_pkg::*;
  import uda_tb_pkg::*;

  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned DrainWait  = 12;
  localparam int unsigned Pow10 [10] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
                                         10000000, 100000000, 1000000000};
  localparam logic [31:0] CornerValues [12] = '{
    32'd0, 32'd1, 32'd9, 32'd10, 32'd99999, 32'd100000, 32'd999999999,
    32'd1000000000, 32'd123456789, 32'd4294900000, 32'hFFFFFFFE, 32'hFFFFFFFF};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  char_t       out_char [NumChars];
  count_t      out_digit_count;

  logic        idle_on = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;

  decimal_text_tracker text_tracker = new();
  decimal_text_t       seen_text;

  uint32_to_decimal_ascii_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_0     (out_char[0]),
    .out_char_1     (out_char[1]),
    .out_char_2     (out_char[2]),
    .out_char_3     (out_char[3]),
    .out_char_4     (out_char[4]),
    .out_char_5     (out_char[5]),
    .out_char_6     (out_char[6]),
    .out_char_7     (out_char[7]),
    .out_char_8     (out_char[8]),
    .out_char_9     (out_char[9]),
    .out_digit_count(out_digit_count)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Result side: checks each accepted word and shapes out_ready.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_text.value = '0;
      for (int i = 0; i < NumChars; i++) seen_text.chars[i] = out_char[i];
      seen_text.count = out_digit_count;
      text_tracker.check_text(seen_text);
    end
    if (hold_requests != holds_served) begin
      holds_served++;
      stall_left = LongHold;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_number(input logic [31:0] value, input bit allow_gap);
    if (allow_gap && idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    text_tracker.note_number(value);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (text_tracker.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_strip_mode(input bit s);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    text_tracker.set_strip(s);
  endtask

  function automatic logic [31:0] random_number();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom % Pow10[$urandom_range(1, 9)];
      7:          return $urandom_range(0, 20);
      8:          return 32'hFFFFFFFF - $urandom_range(0, 1000);
      default:    return Pow10[$urandom_range(0, 9)] - $urandom_range(0, 1);
    endcase
  endfunction

  task automatic send_random_numbers(input int unsigned n, input bit allow_gap);
    for (int unsigned i = 0; i < n; i++) send_number(random_number(), allow_gap);
  endtask

  task automatic send_corner_values();
    foreach (CornerValues[i]) send_number(CornerValues[i], 1'b1);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_corner_values();
    wait_drained();
    write_strip_mode(1'b1);
    send_corner_values();
    wait_drained();

    send_random_numbers(120, 1'b1);
    wait_drained();

    write_strip_mode(1'b0);
    hold_requests <= hold_requests + 1;
    send_random_numbers(60, 1'b0);
    send_random_numbers(40, 1'b1);
    wait_drained();

    write_strip_mode(1'b1);
    send_random_numbers(60, 1'b1);
    wait_drained();
    send_random_numbers(60, 1'b1);
    wait_drained();

    write_strip_mode(1'b0);
    send_random_numbers(60, 1'b1);
    wait_drained();

    write_strip_mode(1'b1);
    idle_on <= 1'b0;
    send_random_numbers(100, 1'b0);
    wait_drained();

    repeat (DrainWait) @(posedge clk);
    if (text_tracker.mismatches == 0 && text_tracker.outstanding() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
